FILE: rtl/dbvr_pkg.sv
`default_nettype none

package dbvr_pkg;

   // Fixed field widths of the channels and of the cell counts.
   localparam int INDEX_W    = 12;
   localparam int COUNT_W    = 13;
   localparam int CELL_CNT_W = 10;

   // One cell is one word of the bit store.
   localparam int CELL_BITS  = 64;
   localparam int OFF_W      = $clog2(CELL_BITS);
   localparam int POP_W      = OFF_W + 1;

   // Word numbers that an index can name.
   localparam int WORD_SEL_W = INDEX_W - OFF_W;
   localparam int WORD_SEL_N = 1 << WORD_SEL_W;

   // Request actions.
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_RANK  = 1'b1;

   // Response status codes.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef logic [CELL_BITS-1:0]  word_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [CELL_CNT_W-1:0] cell_count_type;
   typedef logic [POP_W-1:0]      pop_type;

   // Number of ones in a word.
   function automatic pop_type popcount(input word_type w);
      pop_type n;
      n = '0;
      for (int i = 0; i < CELL_BITS; i++) begin
         n = n + POP_W'(w[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/dbvr_req_if.sv
`default_nettype none

interface dbvr_req_if
   import dbvr_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               action;
   logic [INDEX_W-1:0] index;
   logic               bit_value;

   modport source (output valid, output action, output index, output bit_value, input ready);
   modport sink   (input valid, input action, input index, input bit_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/dbvr_rsp_if.sv
`default_nettype none

interface dbvr_rsp_if
   import dbvr_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] rank_count;
   logic               status;

   modport source (output valid, output rank_count, output status, input ready);
   modport sink   (input valid, input rank_count, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/dbvr_ram.sv
`default_nettype none

module dbvr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/dynamic_bit_vector_rank_unit.sv
`default_nettype none

// Bit store with a two-level rank directory (sample counts and cell counts).
// Words come in on req_ch (valid/ready): action selects a bit write or a rank
// query at index. Every request word yields exactly one response word on
// rsp_ch: the rank (ones at positions 0..index) and a status that flags an
// index at or beyond NUM_BITS. Writes answer with a zero count.
// One request is in flight at a time; req_ch.ready is high only while idle.
// A rank query reads the word, cell and sample stores at once; its response is
// summed in ST_CHECK and ST_RANK_SUM and registered from ST_FINISH.
// A write that changes a bit walks every later sample count through one shared
// adder (one per cycle, pipelined with the sample RAM read) and then rebuilds
// the cell counts of its sample (one word popcount per cycle). A write that
// leaves the bit unchanged goes from ST_CHECK straight to ST_FINISH.
// After reset a clearing pass zeroes all three stores, one address per cycle;
// no request is taken then.
// The response sits in an output register; a stalled receiver holds it there
// while the next request is already being worked on, and only the following
// response waits for that register to drain.
module dynamic_bit_vector_rank_unit
   import dbvr_pkg::*;
#(
   parameter int NUM_BITS         = 4096,
   parameter int CELLS_PER_SAMPLE = 8
) (
   input wire logic   clock,
   input wire logic   reset,
   dbvr_req_if.sink   req_ch,
   dbvr_rsp_if.source rsp_ch
);

   localparam int NUM_WORDS   = (NUM_BITS + CELL_BITS - 1) / CELL_BITS;
   localparam int SAMPLE_BITS = CELLS_PER_SAMPLE * CELL_BITS;
   localparam int NUM_SAMPLES = (NUM_BITS - 1) / SAMPLE_BITS + 2;
   localparam int WA_W        = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
   localparam int SA_W        = $clog2(NUM_SAMPLES);
   localparam int CLR_DEPTH   = NUM_WORDS > NUM_SAMPLES ? NUM_WORDS : NUM_SAMPLES;
   localparam int CLR_W       = $clog2(CLR_DEPTH);
   localparam bit RANGE_ALL   = NUM_BITS >= (1 << INDEX_W);
   localparam logic [INDEX_W-1:0] INDEX_LIMIT = RANGE_ALL ? '1 : INDEX_W'(NUM_BITS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_RANK_SUM,
      ST_SAMPLES,
      ST_CELLS,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [CLR_W-1:0]    clr_ff, clr_in;
   logic                action_ff, action_in;
   logic                val_ff, val_in;
   logic [OFF_W-1:0]    off_ff, off_in;
   logic [WA_W-1:0]     word_ff, word_in;
   logic [WA_W-1:0]     c_rd_ff, c_rd_in;
   logic [WA_W-1:0]     c_last_ff, c_last_in;
   logic [WA_W-1:0]     cw_ff, cw_in;
   logic [SA_W:0]       s_rd_ff, s_rd_in;
   logic [SA_W-1:0]     s_wr_ff, s_wr_in;
   logic                pend_ff, pend_in;
   cell_count_type      acc_ff, acc_in;
   count_type           sum_ff, sum_in;
   pop_type             pop_ff, pop_in;
   count_type           res_count_ff, res_count_in;
   logic                res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   count_type           rsp_count_ff, rsp_count_in;
   logic                rsp_status_ff, rsp_status_in;

   // Elaboration-time tables indexed by the word number of a request.
   logic [SA_W-1:0]     sample_lut [WORD_SEL_N];
   logic [WA_W-1:0]     c0_lut     [WORD_SEL_N];
   logic [WA_W-1:0]     clast_lut  [WORD_SEL_N];

   // Memory ports.
   logic                word_wr_en, word_rd_en;
   logic [WA_W-1:0]     word_wr_addr, word_rd_addr;
   word_type            word_wr_data, word_rd;
   logic                cell_wr_en, cell_rd_en;
   logic [WA_W-1:0]     cell_wr_addr;
   cell_count_type      cell_wr_data, cell_rd;
   logic                samp_wr_en, samp_rd_en;
   logic [SA_W-1:0]     samp_wr_addr, samp_rd_addr;
   count_type           samp_wr_data, samp_rd;

   // Shared adder and popcount.
   count_type           add_a, add_b, add_sum;
   word_type            pop_word;
   pop_type             pop_cnt;

   logic [WORD_SEL_W-1:0] req_word;
   logic                req_in_range;
   logic                s_issue, c_issue, clr_words, clr_samps;
   word_type            bit_mask, rank_mask;

   // Word to sample and cell range tables.
   for (genvar w = 0; w < WORD_SEL_N; w++) begin : g_lut
      localparam int C0   = (w / CELLS_PER_SAMPLE) * CELLS_PER_SAMPLE;
      localparam int CEND = (C0 + CELLS_PER_SAMPLE > NUM_WORDS) ? NUM_WORDS
                                                                 : C0 + CELLS_PER_SAMPLE;
      assign sample_lut[w] = SA_W'(w / CELLS_PER_SAMPLE);
      assign c0_lut[w]     = WA_W'(C0);
      assign clast_lut[w]  = WA_W'(CEND - 1);
   end

   dbvr_ram #(.WIDTH(CELL_BITS), .DEPTH(NUM_WORDS)) u_word_ram (
      .clock  (clock),
      .wr_en  (word_wr_en),
      .wr_addr(word_wr_addr),
      .wr_data(word_wr_data),
      .rd_en  (word_rd_en),
      .rd_addr(word_rd_addr),
      .rd_data(word_rd)
   );

   dbvr_ram #(.WIDTH(CELL_CNT_W), .DEPTH(NUM_WORDS)) u_cell_ram (
      .clock  (clock),
      .wr_en  (cell_wr_en),
      .wr_addr(cell_wr_addr),
      .wr_data(cell_wr_data),
      .rd_en  (cell_rd_en),
      .rd_addr(word_rd_addr),
      .rd_data(cell_rd)
   );

   dbvr_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_SAMPLES)) u_samp_ram (
      .clock  (clock),
      .wr_en  (samp_wr_en),
      .wr_addr(samp_wr_addr),
      .wr_data(samp_wr_data),
      .rd_en  (samp_rd_en),
      .rd_addr(samp_rd_addr),
      .rd_data(samp_rd)
   );

   // Shared arithmetic.
   assign add_sum = add_a + add_b;
   assign pop_cnt = popcount(pop_word);

   assign req_word     = req_ch.index[INDEX_W-1:OFF_W];
   assign req_in_range = RANGE_ALL || (req_ch.index < INDEX_LIMIT);
   assign s_issue      = s_rd_ff < (SA_W+1)'(NUM_SAMPLES);
   assign c_issue      = c_rd_ff != c_last_ff;
   assign clr_words    = {1'b0, clr_ff} < (CLR_W+1)'(NUM_WORDS);
   assign clr_samps    = {1'b0, clr_ff} < (CLR_W+1)'(NUM_SAMPLES);
   assign bit_mask     = word_type'(1) << off_ff;
   assign rank_mask    = {CELL_BITS{1'b1}} >> (OFF_W'(CELL_BITS - 1) - off_ff);

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.rank_count = rsp_count_ff;
   assign rsp_ch.status     = rsp_status_ff;

   // Sequencer: next state, memory controls and shared unit operands.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      action_in     = action_ff;
      val_in        = val_ff;
      off_in        = off_ff;
      word_in       = word_ff;
      c_rd_in       = c_rd_ff;
      c_last_in     = c_last_ff;
      cw_in         = cw_ff;
      s_rd_in       = s_rd_ff;
      s_wr_in       = s_wr_ff;
      pend_in       = pend_ff;
      acc_in        = acc_ff;
      sum_in        = sum_ff;
      pop_in        = pop_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      word_wr_en    = 1'b0;
      word_wr_addr  = word_ff;
      word_wr_data  = '0;
      word_rd_en    = 1'b0;
      word_rd_addr  = c_rd_ff;
      cell_wr_en    = 1'b0;
      cell_wr_addr  = c_rd_ff;
      cell_wr_data  = '0;
      cell_rd_en    = 1'b0;
      samp_wr_en    = 1'b0;
      samp_wr_addr  = s_wr_ff;
      samp_wr_data  = '0;
      samp_rd_en    = 1'b0;
      samp_rd_addr  = SA_W'(s_rd_ff);

      add_a         = '0;
      add_b         = '0;
      pop_word      = '0;

      // The receiver took the waiting response.
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            word_wr_en   = clr_words;
            word_wr_addr = WA_W'(clr_ff);
            cell_wr_en   = clr_words;
            cell_wr_addr = WA_W'(clr_ff);
            samp_wr_en   = clr_samps;
            samp_wr_addr = SA_W'(clr_ff);
            clr_in       = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(CLR_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            word_rd_addr = WA_W'(req_word);
            samp_rd_addr = sample_lut[req_word];
            if (req_ch.valid) begin
               action_in = req_ch.action;
               val_in    = req_ch.bit_value;
               off_in    = req_ch.index[OFF_W-1:0];
               word_in   = WA_W'(req_word);
               c_rd_in   = c0_lut[req_word];
               c_last_in = clast_lut[req_word];
               s_rd_in   = (SA_W+1)'(sample_lut[req_word]) + (SA_W+1)'(1);
               if (req_in_range) begin
                  word_rd_en = 1'b1;
                  cell_rd_en = 1'b1;
                  samp_rd_en = 1'b1;
                  state_in   = ST_CHECK;
               end else begin
                  res_count_in  = '0;
                  res_status_in = STATUS_RANGE;
                  state_in      = ST_FINISH;
               end
            end
         end

         ST_CHECK: begin
            res_count_in  = '0;
            res_status_in = STATUS_OK;
            if (action_ff == ACTION_RANK) begin
               // First half of the rank: sample plus cell count, word popcount.
               pop_word = word_rd & rank_mask;
               pop_in   = pop_cnt;
               add_a    = samp_rd;
               add_b    = COUNT_W'(cell_rd);
               sum_in   = add_sum;
               state_in = ST_RANK_SUM;
            end else if (word_rd[off_ff] == val_ff) begin
               state_in = ST_FINISH;
            end else begin
               // Store the changed word and start the directory update.
               word_wr_en   = 1'b1;
               word_wr_data = val_ff ? (word_rd | bit_mask) : (word_rd & ~bit_mask);
               cell_wr_en   = 1'b1;
               acc_in       = '0;
               pend_in      = 1'b0;
               state_in     = ST_SAMPLES;
            end
         end

         ST_RANK_SUM: begin
            add_a        = sum_ff;
            add_b        = COUNT_W'(pop_ff);
            res_count_in = add_sum;
            state_in     = ST_FINISH;
         end

         ST_SAMPLES: begin
            // Read the next sample count while writing back the previous one.
            samp_rd_en = s_issue;
            pend_in    = s_issue;
            if (s_issue) begin
               s_rd_in = s_rd_ff + (SA_W+1)'(1);
               s_wr_in = SA_W'(s_rd_ff);
            end
            if (pend_ff) begin
               add_a        = samp_rd;
               add_b        = val_ff ? COUNT_W'(1) : '1;
               samp_wr_en   = 1'b1;
               samp_wr_data = add_sum;
               if (!s_issue) begin
                  state_in = c_issue ? ST_CELLS : ST_FINISH;
               end
            end
         end

         ST_CELLS: begin
            // Popcount one word per cycle into the running cell prefix.
            word_rd_en = c_issue;
            pend_in    = c_issue;
            if (c_issue) begin
               c_rd_in = c_rd_ff + WA_W'(1);
               cw_in   = c_rd_ff;
            end
            if (pend_ff) begin
               pop_word     = word_rd;
               add_a        = COUNT_W'(acc_ff);
               add_b        = COUNT_W'(pop_cnt);
               cell_wr_en   = 1'b1;
               cell_wr_addr = cw_ff + WA_W'(1);
               cell_wr_data = add_sum[CELL_CNT_W-1:0];
               acc_in       = add_sum[CELL_CNT_W-1:0];
               if (!c_issue) begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = res_count_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff     <= action_in;
      val_ff        <= val_in;
      off_ff        <= off_in;
      word_ff       <= word_in;
      c_rd_ff       <= c_rd_in;
      c_last_ff     <= c_last_in;
      cw_ff         <= cw_in;
      s_rd_ff       <= s_rd_in;
      s_wr_ff       <= s_wr_in;
      acc_ff        <= acc_in;
      sum_ff        <= sum_in;
      pop_ff        <= pop_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   // A pending read-modify-write exists only during the directory walks.
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_SAMPLES || state_ff == ST_CELLS))
      else $error("pending directory update outside the walk states");

   // The cell walk never passes the last cell of its sample.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CELLS |-> c_rd_ff <= c_last_ff)
      else $error("cell walk ran past the end of its sample");

   // A write always answers with a zero count.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && action_ff == ACTION_WRITE |-> res_count_ff == '0)
      else $error("write produced a nonzero count");

   // An out-of-range response carries no count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_RANGE |-> rsp_count_ff == '0)
      else $error("range error response with a nonzero count");

   // No request is taken before the clearing pass ends.
   assert property (@(posedge clock) disable iff (reset)
      $past(state_ff) == ST_CLEAR && state_ff != ST_IDLE |-> state_ff == ST_CLEAR)
      else $error("clearing pass left for a state other than idle");

endmodule

`default_nettype wire
